// ===== src/rgbled_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, codes and defaults for the RGB LED strip serial driver.
// ----------------------------------------------------------------------------
package rgbled_pkg;

    // Build-time defaults for the top-level parameters
    localparam int MAX_PIXELS_DEF     = 256;
    localparam int MAX_BRIGHTNESS_DEF = 128;

    // Field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Request codes
    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_FILL  = 3'd1;
    localparam logic [2:0] REQ_SHOW  = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_BUSY  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH       = 3'd6;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  pixel_index;
        logic [23:0] pixel_color;
    } rgbled_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       line_level;
        logic       frame_done;
    } rgbled_rsp_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_SWEEP,
        CTL_READ,
        CTL_SCALE_GO,
        CTL_SCALE_WAIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        SCL_IDLE,
        SCL_MUL,
        SCL_EST,
        SCL_FIX
    } scl_state_t;

endpackage
`default_nettype wire

// ===== src/rgb_led_strip_serial_driver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_strip_serial_driver
// Single-wire RGB LED strip driver: pixel store, fill/clear, frame serializer.
// ----------------------------------------------------------------------------
// Response: every request gets its response in the output register in the cycle
//   after it is accepted.
// Busy time: a write, start-less tick or ignored code ends at acceptance.
//   A tick that finishes a byte other than the frame's last also runs the
//   store read, the 8-step serial brightness multiply and the /255 fix-up.
//   Fill and clear sweep the used entries; clear and start frame load a byte.
// Reset: synchronous active-low; afterwards a clearing pass writes zero to all
//   MAX_PIXELS store entries with s_ready low.
module rgb_led_strip_serial_driver
    import rgbled_pkg::*;
#(
    parameter int MAX_PIXELS     = MAX_PIXELS_DEF,
    parameter int MAX_BRIGHTNESS = MAX_BRIGHTNESS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rgbled_req_t           s_data,
    // response channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rgbled_rsp_t                m_data,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Store address width, and a count width that holds both MAX_PIXELS and
    // the 9-bit pixel_count register.
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int NW = (CW > 9) ? CW : 9;
    localparam logic [NW-1:0]  MaxPix    = NW'(MAX_PIXELS);
    localparam logic [7:0]     MaxBright = 8'(MAX_BRIGHTNESS);

    // ---------------- configuration registers ----------------
    logic [8:0]  pixel_count_reg;
    logic [7:0]  brightness_reg;
    logic [7:0]  zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [15:0] latch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= 9'd1;
            brightness_reg  <= 8'd0;
            zero_high_reg   <= 8'd4;
            zero_low_reg    <= 8'd8;
            one_high_reg    <= 8'd8;
            one_low_reg     <= 8'd4;
            latch_reg       <= 16'd1000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data[8:0];
                CFG_BRIGHTNESS:  brightness_reg  <= cfg_data[7:0];
                CFG_ZERO_HIGH:   zero_high_reg   <= cfg_data[7:0];
                CFG_ZERO_LOW:    zero_low_reg    <= cfg_data[7:0];
                CFG_ONE_HIGH:    one_high_reg    <= cfg_data[7:0];
                CFG_ONE_LOW:     one_low_reg     <= cfg_data[7:0];
                CFG_LATCH:       latch_reg       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective pixel count: 0 acts as 1, capped at the store depth
    logic [NW-1:0] pc_ext;
    logic [NW-1:0] used_n;
    assign pc_ext = NW'(pixel_count_reg);
    assign used_n = (pc_ext == '0) ? NW'(1) : ((pc_ext > MaxPix) ? MaxPix : pc_ext);

    // Effective brightness, clamped to the build maximum
    logic [7:0] bright_used;
    assign bright_used = (brightness_reg > MaxBright) ? MaxBright : brightness_reg;

    // ---------------- pixel store ----------------
    logic [23:0]   mem [MAX_PIXELS];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [23:0]   mem_wdata;
    logic [23:0]   rd_data_reg;

    // ---------------- control / serializer state ----------------
    ctl_state_t    state_reg, state_next;
    logic          sending_reg, sending_next;
    logic          gap_reg, gap_next;
    logic          high_reg, high_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [1:0]    chan_reg, chan_next;
    logic [2:0]    bit_reg, bit_next;
    logic [7:0]    shift_byte_reg, shift_byte_next;
    logic [15:0]   tick_count_reg, tick_count_next;
    logic [NW-1:0] sweep_reg, sweep_next;
    logic [NW-1:0] sweep_lim_reg, sweep_lim_next;
    logic [23:0]   sweep_color_reg, sweep_color_next;
    logic          sweep_start_reg, sweep_start_next;
    logic          m_valid_reg, m_valid_next;
    rgbled_rsp_t   m_data_reg, m_data_next;

    // scaler hookup
    logic          scl_start;
    logic [7:0]    scl_value;
    logic          scl_done;
    logic [7:0]    scl_result;

    // combinational helpers
    logic          accept;
    logic [NW-1:0] idx_ext;
    logic [NW-1:0] ptr_plus;
    logic [NW-1:0] sweep_plus;
    logic [15:0]   tick_plus;
    logic [7:0]    part_ticks;
    logic          bit_one;

    assign s_ready    = (state_reg == CTL_IDLE) && (!m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    assign idx_ext    = NW'(s_data.pixel_index);
    assign ptr_plus   = NW'(ptr_reg) + NW'(1);
    assign sweep_plus = sweep_reg + NW'(1);
    assign tick_plus  = tick_count_reg + 16'd1;
    assign bit_one    = shift_byte_reg[7];

    // Length of the current bit part, picked by part and bit value
    always_comb begin
        if (high_reg) begin
            part_ticks = bit_one ? one_high_reg : zero_high_reg;
        end else begin
            part_ticks = bit_one ? one_low_reg : zero_low_reg;
        end
    end

    // Byte of the current pixel for the active channel: red, green, blue
    always_comb begin
        case (chan_reg)
            2'd0:    scl_value = rd_data_reg[23:16];
            2'd1:    scl_value = rd_data_reg[15:8];
            default: scl_value = rd_data_reg[7:0];
        endcase
    end

    rgbled_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scl_start),
        .value   (scl_value),
        .bright  (bright_used),
        .done    (scl_done),
        .result  (scl_result)
    );

    // Store: one write port, one registered read port on the pixel pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    // Control state; after reset the sweep clears the whole store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= CTL_SWEEP;
            sending_reg     <= 1'b0;
            gap_reg         <= 1'b0;
            high_reg        <= 1'b0;
            ptr_reg         <= '0;
            chan_reg        <= '0;
            bit_reg         <= '0;
            shift_byte_reg  <= '0;
            tick_count_reg  <= '0;
            sweep_reg       <= '0;
            sweep_lim_reg   <= MaxPix;
            sweep_color_reg <= '0;
            sweep_start_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sending_reg     <= sending_next;
            gap_reg         <= gap_next;
            high_reg        <= high_next;
            ptr_reg         <= ptr_next;
            chan_reg        <= chan_next;
            bit_reg         <= bit_next;
            shift_byte_reg  <= shift_byte_next;
            tick_count_reg  <= tick_count_next;
            sweep_reg       <= sweep_next;
            sweep_lim_reg   <= sweep_lim_next;
            sweep_color_reg <= sweep_color_next;
            sweep_start_reg <= sweep_start_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // response payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next       = state_reg;
        sending_next     = sending_reg;
        gap_next         = gap_reg;
        high_next        = high_reg;
        ptr_next         = ptr_reg;
        chan_next        = chan_reg;
        bit_next         = bit_reg;
        shift_byte_next  = shift_byte_reg;
        tick_count_next  = tick_count_reg;
        sweep_next       = sweep_reg;
        sweep_lim_next   = sweep_lim_reg;
        sweep_color_next = sweep_color_reg;
        sweep_start_next = sweep_start_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        mem_we           = 1'b0;
        mem_addr         = idx_ext[AW-1:0];
        mem_wdata        = s_data.pixel_color;
        scl_start        = 1'b0;

        case (state_reg)
            CTL_IDLE: begin
                if (accept) begin
                    // Every response is known at acceptance; only the store
                    // and byte-load work can take extra cycles.
                    m_valid_next           = 1'b1;
                    m_data_next.status     = STATUS_OK;
                    m_data_next.line_level = 1'b0;
                    m_data_next.frame_done = 1'b0;

                    if (sending_reg && (s_data.req_type inside
                            {REQ_WRITE, REQ_FILL, REQ_SHOW, REQ_CLEAR})) begin
                        m_data_next.status = STATUS_BUSY;
                    end else begin
                        case (s_data.req_type)
                            REQ_WRITE: begin
                                if (idx_ext < used_n) begin
                                    mem_we = 1'b1;
                                end else begin
                                    m_data_next.status = STATUS_RANGE;
                                end
                            end
                            REQ_FILL: begin
                                sweep_next       = '0;
                                sweep_lim_next   = used_n;
                                sweep_color_next = s_data.pixel_color;
                                sweep_start_next = 1'b0;
                                state_next       = CTL_SWEEP;
                            end
                            REQ_SHOW, REQ_CLEAR: begin
                                sending_next    = 1'b1;
                                gap_next        = 1'b0;
                                ptr_next        = '0;
                                chan_next       = '0;
                                bit_next        = '0;
                                high_next       = 1'b1;
                                tick_count_next = '0;
                                if (s_data.req_type == REQ_CLEAR) begin
                                    sweep_next       = '0;
                                    sweep_lim_next   = used_n;
                                    sweep_color_next = '0;
                                    sweep_start_next = 1'b1;
                                    state_next       = CTL_SWEEP;
                                end else begin
                                    state_next = CTL_READ;
                                end
                            end
                            REQ_TICK: begin
                                if (sending_reg && gap_reg) begin
                                    // reset gap; wrap to zero also ends it
                                    if (tick_plus >= latch_reg || tick_plus == 16'd0) begin
                                        sending_next           = 1'b0;
                                        gap_next               = 1'b0;
                                        high_next              = 1'b0;
                                        tick_count_next        = '0;
                                        m_data_next.frame_done = 1'b1;
                                    end else begin
                                        tick_count_next = tick_plus;
                                    end
                                end else if (sending_reg) begin
                                    m_data_next.line_level = high_reg;
                                    if (tick_plus >= {8'd0, part_ticks}) begin
                                        tick_count_next = '0;
                                        if (high_reg) begin
                                            high_next = 1'b0;
                                        end else begin
                                            // end of bit: next bit, byte or pixel
                                            high_next       = 1'b1;
                                            bit_next        = bit_reg + 3'd1;
                                            shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                                            if (bit_reg == 3'd7) begin
                                                if (chan_reg == 2'd2) begin
                                                    chan_next = '0;
                                                    if (ptr_plus >= used_n) begin
                                                        gap_next        = 1'b1;
                                                        ptr_next        = '0;
                                                        shift_byte_next = '0;
                                                    end else begin
                                                        ptr_next   = ptr_plus[AW-1:0];
                                                        state_next = CTL_READ;
                                                    end
                                                end else begin
                                                    chan_next  = chan_reg + 2'd1;
                                                    state_next = CTL_READ;
                                                end
                                            end
                                        end
                                    end else begin
                                        tick_count_next = tick_plus;
                                    end
                                end
                            end
                            default: begin
                                // unknown codes are ignored
                            end
                        endcase
                    end
                end
            end
            CTL_SWEEP: begin
                // one store entry per cycle
                mem_we     = 1'b1;
                mem_addr   = sweep_reg[AW-1:0];
                mem_wdata  = sweep_color_reg;
                sweep_next = sweep_plus;
                if (sweep_plus >= sweep_lim_reg) begin
                    sweep_next       = '0;
                    sweep_start_next = 1'b0;
                    state_next       = sweep_start_reg ? CTL_READ : CTL_IDLE;
                end
            end
            CTL_READ: begin
                // rd_data_reg picks up the pixel at ptr_reg on this edge
                state_next = CTL_SCALE_GO;
            end
            CTL_SCALE_GO: begin
                scl_start  = 1'b1;
                state_next = CTL_SCALE_WAIT;
            end
            CTL_SCALE_WAIT: begin
                if (scl_done) begin
                    shift_byte_next = scl_result;
                    state_next      = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/rgbled_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbled_scale
// Bit-serial brightness scaler: result = value * bright / 255, truncated.
// ----------------------------------------------------------------------------
module rgbled_scale
    import rgbled_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start,
    input  wire logic [7:0] value,
    input  wire logic [7:0] bright,
    output logic            done,
    output logic [7:0]      result
);

    scl_state_t  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  mcand_reg, mcand_next;
    logic [7:0]  mplier_reg, mplier_next;
    logic [15:0] prod_reg, prod_next;
    logic [7:0]  quot_reg, quot_next;
    logic [15:0] est_sum;
    logic [15:0] rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCL_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        quot_reg   <= quot_next;
    end

    // x/255 estimate (x + x>>8) >> 8 is low by at most one
    assign est_sum = prod_reg + {8'd0, prod_reg[15:8]};
    assign rem     = prod_reg - {quot_reg, 8'd0} + {8'd0, quot_reg};

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        quot_next   = quot_reg;
        done        = 1'b0;
        result      = quot_reg;
        case (state_reg)
            SCL_IDLE: begin
                if (start) begin
                    mcand_next  = value;
                    mplier_next = bright;
                    prod_next   = '0;
                    cnt_next    = '0;
                    state_next  = SCL_MUL;
                end
            end
            SCL_MUL: begin
                // MSB-first shift-add, one multiplier bit per cycle
                prod_next   = {prod_reg[14:0], 1'b0}
                            + (mplier_reg[7] ? {8'd0, mcand_reg} : 16'd0);
                mplier_next = {mplier_reg[6:0], 1'b0};
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    state_next = SCL_EST;
                end
            end
            SCL_EST: begin
                quot_next  = est_sum[15:8];
                state_next = SCL_FIX;
            end
            SCL_FIX: begin
                if (rem >= 16'd255) begin
                    result = quot_reg + 8'd1;
                end
                done       = 1'b1;
                state_next = SCL_IDLE;
            end
            default: begin
                state_next = SCL_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
